@@ rtl/ipsd_pkg.sv @@
// Package for the ink point stream decoder.
// Holds result codes, register indexes, reset values, shared structs and
// the hex digit helper. No dependencies.
package ipsd_pkg;

  localparam int DefPointLimit  = 4096;
  localparam int DefStrokeLimit = 256;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_SEP   = 2'd2;

  localparam logic [1:0] REG_MAX_X       = 2'd0;
  localparam logic [1:0] REG_AREA_TOP    = 2'd1;
  localparam logic [1:0] REG_AREA_BOTTOM = 2'd2;

  localparam logic [9:0] MAX_X_RST       = 10'd319;
  localparam logic [9:0] AREA_TOP_RST    = 10'd0;
  localparam logic [9:0] AREA_BOTTOM_RST = 10'd239;

  localparam logic [3:0] CHUNK_LAST_POS = 4'd9;
  localparam logic [3:0] SEP_F_COUNT    = 4'd8;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [15:0] DROP_COORD    = 16'hFFFF;

  typedef struct packed {
    logic [9:0] max_x;
    logic [9:0] area_top;
    logic [9:0] area_bottom;
  } cfg_t;

  typedef struct packed {
    logic [39:0] bytes;
    logic [3:0]  fill;
    logic        sep_text;
    logic        prev_sep;
    logic        lead_bad;
  } chunk_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  x_pos;
    logic [9:0]  y_pos;
    logic        erase_bit;
    logic [1:0]  size_index;
    logic [3:0]  colour_index;
    logic        stroke_begins;
    logic [11:0] slot_index;
    logic        done_res;
    logic [12:0] point_total;
    logic [8:0]  stroke_total;
  } result_t;

  localparam chunk_t CHUNK_RST = '{bytes: '0, fill: '0, sep_text: 1'b1,
                                   prev_sep: 1'b0, lead_bad: 1'b0};

  // bit 4 set marks a valid digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

@@ rtl/ipsd_cfg_regs.sv @@
// Configuration registers of the ink point stream decoder.
// Depends on ipsd_pkg for register indexes and reset values.
module ipsd_cfg_regs import ipsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [9:0] wr_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_x       <= MAX_X_RST;
      cfg.area_top    <= AREA_TOP_RST;
      cfg.area_bottom <= AREA_BOTTOM_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_X:       cfg.max_x       <= wr_data;
        REG_AREA_TOP:    cfg.area_top    <= wr_data;
        REG_AREA_BOTTOM: cfg.area_bottom <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ipsd_decode.sv @@
// Single-pass decode of one character: chunk assembly, point and separator
// classification, clamping and counter update. Depends on ipsd_pkg.
module ipsd_decode import ipsd_pkg::*; #(
  parameter int POINT_LIMIT  = DefPointLimit,
  parameter int STROKE_LIMIT = DefStrokeLimit,
  localparam int PW = $clog2(POINT_LIMIT + 1),
  localparam int SW = $clog2(STROKE_LIMIT + 1)
) (
  input  logic [7:0]    ch,
  input  logic          last,
  input  cfg_t          cfg,
  input  chunk_t        st,
  input  logic [PW-1:0] points,
  input  logic [SW-1:0] strokes,
  output chunk_t        st_next,
  output logic [PW-1:0] points_next,
  output logic [SW-1:0] strokes_next,
  output logic          res_valid,
  output result_t       res
);

  logic [4:0]     dig;
  logic [2:0]     k;
  logic [7:0]     cur_byte;
  logic [7:0]     v;
  logic [7:0]     sep_ch;
  logic [39:0]    bytes_new;
  logic           sep_now;
  logic           complete;
  logic           room;
  logic           starts;
  logic [15:0]    x_raw;
  logic [15:0]    y_raw;
  logic [15:0]    y_top;
  logic [15:0]    y_clamp;
  logic [7:0]     prop;
  logic [PW+12:0] pt_ext;
  logic [PW+11:0] slot_ext;
  logic [SW+8:0]  sk_ext;

  assign dig      = hex_digit(ch);
  assign k        = st.fill[3:1];
  assign cur_byte = st.bytes[8*k +: 8];
  assign sep_ch   = (st.fill < SEP_F_COUNT) ? CHAR_UPPER_F : CHAR_ZERO;
  assign sep_now  = st.sep_text && (ch == sep_ch);
  assign complete = (st.fill == CHUNK_LAST_POS);

  always_comb begin
    if (!st.fill[0]) v = dig[4] ? {4'd0, dig[3:0]} : 8'd0;
    else if (!st.lead_bad && dig[4]) v = {cur_byte[3:0], dig[3:0]};
    else v = cur_byte;
    bytes_new = st.bytes;
    bytes_new[8*k +: 8] = v;
  end

  assign x_raw   = bytes_new[15:0];
  assign y_raw   = bytes_new[31:16];
  assign prop    = bytes_new[39:32];
  assign y_top   = (y_raw < {6'd0, cfg.area_top}) ? {6'd0, cfg.area_top} : y_raw;
  assign y_clamp = (y_top > {6'd0, cfg.area_bottom}) ? {6'd0, cfg.area_bottom} : y_top;
  assign room    = (points < PW'(POINT_LIMIT)) && (strokes < SW'(STROKE_LIMIT));
  assign starts  = (points == '0) || st.prev_sep;

  always_comb begin
    logic [PW-1:0] pts;
    logic [SW-1:0] sks;
    logic          emit;
    pts     = points;
    sks     = strokes;
    emit    = 1'b0;
    res     = '0;
    st_next = st;
    st_next.bytes    = bytes_new;
    st_next.fill     = st.fill + 4'd1;
    st_next.sep_text = sep_now;
    if (!st.fill[0]) st_next.lead_bad = !dig[4];

    if (complete) begin
      if (room) begin
        if (sep_now) begin
          res.kind       = KIND_SEP;
          pts  = points + PW'(1);
          st_next.prev_sep = 1'b1;
          emit = 1'b1;
        end else if (x_raw != DROP_COORD || y_raw != DROP_COORD) begin
          res.kind          = KIND_POINT;
          res.x_pos         = (x_raw > {6'd0, cfg.max_x}) ? cfg.max_x : x_raw[9:0];
          res.y_pos         = y_clamp[9:0];
          res.erase_bit     = prop[0];
          res.size_index    = prop[2:1];
          res.colour_index  = prop[6:3];
          res.stroke_begins = starts;
          pts  = points + PW'(1);
          if (starts) sks = strokes + SW'(1);
          st_next.prev_sep = 1'b0;
          emit = 1'b1;
        end
      end
      st_next.bytes    = '0;
      st_next.fill     = '0;
      st_next.sep_text = 1'b1;
      st_next.lead_bad = 1'b0;
    end

    slot_ext         = {12'd0, points};
    if (emit) res.slot_index = slot_ext[11:0];
    pt_ext           = {13'd0, pts};
    sk_ext           = {9'd0, sks};
    res.done_res     = last;
    res.point_total  = pt_ext[12:0];
    res.stroke_total = sk_ext[8:0];
    res_valid        = emit || last;

    points_next  = pts;
    strokes_next = sks;
    if (last) begin
      st_next      = CHUNK_RST;
      points_next  = '0;
      strokes_next = '0;
    end
  end

endmodule

@@ rtl/ipsd_top_wrap_placeholder.sv @@
// Output staging register of the ink point stream decoder.
// Holds one result item until the downstream side takes it. Depends on ipsd_pkg.
module ipsd_out_reg import ipsd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    load_valid,
  input  result_t load_res,
  input  logic    stall,
  output logic    free,
  output logic    valid,
  output result_t res
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && load_valid) res <= load_res;
  end

endmodule

@@ rtl/ink_point_stream_decoder.sv @@
// Top level of the ink point stream decoder: input register, chunk state,
// decode and output register. Depends on ipsd_pkg, ipsd_cfg_regs,
// ipsd_decode and ipsd_out_reg.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+----------------------
//  input   | char_in, last_char               | in_valid / in_stall
//  output  | kind .. stroke_total             | out_valid / out_stall
//  config  | cfg_index, cfg_data              | cfg_valid / cfg_ready
//
// One character per cycle while in_stall is low; a taken character is held in the input
// register, then decoded, and any result it yields is loaded into the result register.
// Reset clears the chunk state, both counters and restores the registers.
// A stalled output holds the result register and then the input register;
// in_stall rises only while both are full.
module ink_point_stream_decoder import ipsd_pkg::*; #(
  parameter int POINT_LIMIT  = DefPointLimit,
  parameter int STROKE_LIMIT = DefStrokeLimit
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [9:0]  x_pos,
  output logic [9:0]  y_pos,
  output logic        erase_bit,
  output logic [1:0]  size_index,
  output logic [3:0]  colour_index,
  output logic        stroke_begins,
  output logic [11:0] slot_index,
  output logic        done_res,
  output logic [12:0] point_total,
  output logic [8:0]  stroke_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int PW = $clog2(POINT_LIMIT + 1);
  localparam int SW = $clog2(STROKE_LIMIT + 1);

  cfg_t          cfg;
  chunk_t        st;
  chunk_t        st_next;
  logic [PW-1:0] points;
  logic [PW-1:0] points_next;
  logic [SW-1:0] strokes;
  logic [SW-1:0] strokes_next;
  logic          s1_valid;
  logic [7:0]    s1_char;
  logic          s1_last;
  logic          s1_adv;
  logic          in_take;
  logic          out_free;
  logic          dec_valid;
  result_t       dec_res;
  result_t       o_res;

  assign cfg_ready = 1'b1;

  ipsd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= char_in;
      s1_last <= last_char;
    end
  end

  ipsd_decode #(
    .POINT_LIMIT  (POINT_LIMIT),
    .STROKE_LIMIT (STROKE_LIMIT)
  ) u_decode (
    .ch           (s1_char),
    .last         (s1_last),
    .cfg          (cfg),
    .st           (st),
    .points       (points),
    .strokes      (strokes),
    .st_next      (st_next),
    .points_next  (points_next),
    .strokes_next (strokes_next),
    .res_valid    (dec_valid),
    .res          (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= CHUNK_RST;
      points  <= '0;
      strokes <= '0;
    end else if (s1_adv) begin
      st      <= st_next;
      points  <= points_next;
      strokes <= strokes_next;
    end
  end

  ipsd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_adv),
    .load_valid (dec_valid),
    .load_res   (dec_res),
    .stall      (out_stall),
    .free       (out_free),
    .valid      (out_valid),
    .res        (o_res)
  );

  assign kind          = o_res.kind;
  assign x_pos         = o_res.x_pos;
  assign y_pos         = o_res.y_pos;
  assign erase_bit     = o_res.erase_bit;
  assign size_index    = o_res.size_index;
  assign colour_index  = o_res.colour_index;
  assign stroke_begins = o_res.stroke_begins;
  assign slot_index    = o_res.slot_index;
  assign done_res      = o_res.done_res;
  assign point_total   = o_res.point_total;
  assign stroke_total  = o_res.stroke_total;

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    st.fill <= CHUNK_LAST_POS)
    else $error("chunk fill out of range");

  a_none_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NONE) |-> done_res)
    else $error("empty result without done");

  a_start_on_point: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stroke_begins) |-> kind == KIND_POINT)
    else $error("stroke start on non-point");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with free space");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (points == '0 && strokes == '0 && st.fill == '0))
    else $error("stream state not cleared after last character");

endmodule
